### sv/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg: shared types and defaults for the merge sorter
// Default sizes and the status flags passed to the compare unit.
// ----------------------------------------------------------------------------
package msort_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // which runs still hold elements in the current merge
    typedef struct packed {
        logic left_avail;
        logic right_avail;
    } run_flags_t;

endpackage

### sv/merge_sorter_top.sv
// ----------------------------------------------------------------------------
// merge_sorter_top: buffered bottom-up merge sorter
// Collects a set of signed values, sorts it ascending by merging runs
// between two buffers (ping-pong), then streams the sorted set out.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                  tlast       tuser
//  s_        in   value                  last        -
//  m_        out  sorted_value           final_res   overflow
//
//  Collect: one request per cycle while s_tready is high.
//  Sort: ceil(log2 n) passes, each merging pairs of runs; the single compare
//  unit and one read port per buffer set the pace of a pass.
//  Output: each result is read, loaded and then held until m_tready takes it.
//  s_tready is low from a last request until the final result is taken.
//  aresetn clears count, overflow flag and control; buffers are not cleared.
// ----------------------------------------------------------------------------
module merge_sorter_top #(
    parameter int DEPTH       = msort_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = msort_pkg::VALUE_WIDTH_DEF,
    localparam int TDW        = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [TDW-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
    input  logic           s_tlast,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [TDW-1:0] m_tdata,   // [VALUE_WIDTH-1:0] sorted_value
    output logic           m_tlast,
    output logic           m_tuser    // [0] overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 2;

    typedef enum logic [3:0] {
        ST_COLLECT, ST_SETUP, ST_RD_A, ST_RD_B, ST_LD_B,
        ST_CMP, ST_FETCH, ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          src_reg, src_next;     // 1: scratch holds the current runs
    logic [CW:0]   width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic          took_r_reg, took_r_next;
    logic          mvalid_reg, mvalid_next;
    logic [VALUE_WIDTH-1:0] mdata_reg, mdata_next;
    logic          mlast_reg, mlast_next;
    logic          muser_reg, muser_next;

    logic          coll_we, mrg_we;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0] wr_data, store_rdata, scratch_rdata, rd_data;
    logic          store_we, scratch_we;
    logic          take_right;
    msort_pkg::run_flags_t flags;
    logic [PW-1:0] n_ext, mid_sum, hi_sum;
    logic          in_req;

    assign in_req = s_tvalid && s_tready;

    assign store_we   = coll_we || (mrg_we && src_reg);
    assign scratch_we = mrg_we && !src_reg;
    assign rd_data    = src_reg ? scratch_rdata : store_rdata;

    msort_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (store_rdata)
    );

    msort_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_scratch (
        .aclk  (aclk),
        .we    (scratch_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (scratch_rdata)
    );

    assign flags.left_avail  = i_reg < mid_reg;
    assign flags.right_avail = j_reg < hi_reg;

    msort_cmp #(.WIDTH(VALUE_WIDTH)) u_cmp (
        .left_val   (a_reg),
        .right_val  (b_reg),
        .flags      (flags),
        .take_right (take_right)
    );

    assign n_ext   = PW'(count_reg);
    assign mid_sum = PW'(lo_reg) + PW'(width_reg);
    assign hi_sum  = PW'(lo_reg) + (PW'(width_reg) << 1);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        src_next    = src_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        took_r_next = took_r_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        muser_next  = muser_reg;
        coll_we     = 1'b0;
        mrg_we      = 1'b0;
        wr_addr     = k_reg[AW-1:0];
        wr_data     = a_reg;
        rd_addr     = k_reg[AW-1:0];
        s_tready    = 1'b0;

        unique case (state_reg)
            ST_COLLECT: begin
                s_tready = 1'b1;
                wr_addr  = count_reg[AW-1:0];
                wr_data  = s_tdata[VALUE_WIDTH-1:0];
                if (in_req) begin
                    if (count_reg < CW'(DEPTH)) begin
                        coll_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        width_next = (CW + 1)'(1);
                        lo_next    = '0;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                if (PW'(width_reg) >= n_ext) begin
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end else if (lo_reg >= count_reg) begin
                    // pass complete: swap buffers, double run length
                    width_next = width_reg << 1;
                    lo_next    = '0;
                    src_next   = !src_reg;
                end else begin
                    mid_next   = (mid_sum > n_ext) ? count_reg : CW'(mid_sum);
                    hi_next    = (hi_sum > n_ext) ? count_reg : CW'(hi_sum);
                    i_next     = lo_reg;
                    j_next     = (mid_sum > n_ext) ? count_reg : CW'(mid_sum);
                    k_next     = lo_reg;
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: begin
                rd_addr    = i_reg[AW-1:0];
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                rd_addr    = j_reg[AW-1:0];
                a_next     = rd_data;
                state_next = ST_LD_B;
            end
            ST_LD_B: begin
                b_next     = rd_data;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                mrg_we      = 1'b1;
                wr_addr     = k_reg[AW-1:0];
                wr_data     = take_right ? b_reg : a_reg;
                k_next      = k_reg + 1'b1;
                took_r_next = take_right;
                if (take_right) begin
                    j_next  = j_reg + 1'b1;
                    rd_addr = j_next[AW-1:0];
                end else begin
                    i_next  = i_reg + 1'b1;
                    rd_addr = i_next[AW-1:0];
                end
                if (k_next == hi_reg) begin
                    lo_next    = hi_reg;
                    state_next = ST_SETUP;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // a read past the end of a run is ignored by the run flags
                if (took_r_reg) begin
                    b_next = rd_data;
                end else begin
                    a_next = rd_data;
                end
                state_next = ST_CMP;
            end
            ST_OUT_RD: begin
                rd_addr    = k_reg[AW-1:0];
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                mdata_next  = rd_data;
                mlast_next  = (k_reg + 1'b1) == count_reg;
                muser_next  = ovf_reg;
                mvalid_next = 1'b1;
                state_next  = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    if (mlast_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        src_next   = 1'b0;
                        state_next = ST_COLLECT;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_COLLECT;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            src_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            src_reg    <= src_next;
            mvalid_reg <= mvalid_next;
        end
        width_reg  <= width_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        took_r_reg <= took_r_next;
        mdata_reg  <= mdata_next;
        mlast_reg  <= mlast_next;
        muser_reg  <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = TDW'(mdata_reg);
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

    // input and output sides are never open at the same time
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output requests open together");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after last request");

    a_final_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count_reg == '0))
        else $error("block not emptied after final result");

    // merged output index tracks the two run heads
    a_merge_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |->
            (PW'(k_reg) + PW'(mid_reg) == PW'(i_reg) + PW'(j_reg)))
        else $error("merge indices out of step");

endmodule

### sv/msort_ram.sv
// ----------------------------------------------------------------------------
// msort_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module msort_ram #(
    parameter int WIDTH = msort_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = msort_pkg::DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/msort_cmp.sv
// ----------------------------------------------------------------------------
// msort_cmp: merge step decision
// Picks the run that supplies the next merged element; ties go right.
// ----------------------------------------------------------------------------
module msort_cmp #(
    parameter int WIDTH = msort_pkg::VALUE_WIDTH_DEF
) (
    input  logic [WIDTH-1:0]      left_val,
    input  logic [WIDTH-1:0]      right_val,
    input  msort_pkg::run_flags_t flags,
    output logic                  take_right
);

    logic left_less;

    assign left_less  = $signed(left_val) < $signed(right_val);
    assign take_right = flags.right_avail && (!flags.left_avail || !left_less);

endmodule

### tb/merge_sorter_top_tb.sv
// ----------------------------------------------------------------------------
// merge_sorter_top_tb: self-checking bench for the buffered merge sorter
// Streams sets of signed values into the sorter: a table of directed sets
// first, then random sets, one of which fills the buffer and overflows.
// A behavioral sorter predicts each result that no table row gives, and every
// result is compared in order. Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module merge_sorter_top_tb;

    localparam int DEPTH      = msort_pkg::DEPTH_DEF;
    localparam int VW         = msort_pkg::VALUE_WIDTH_DEF;
    localparam int TDW        = ((VW + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 10000;
    localparam int DIR_ROWS   = 20;
    localparam int RAND_ITEMS = 110;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          fin;
        logic          ovf;
    } sorted_res_t;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          is_last;
        logic          typed;      // expectation given in the row
        logic [VW-1:0] exp_value;
        logic          exp_fin;
        logic          exp_ovf;
    } stim_row_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [TDW-1:0] s_tdata  = '0;     // [VW-1:0] value
    logic           s_tlast  = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [TDW-1:0] m_tdata;           // [VW-1:0] sorted_value
    logic           m_tlast;
    logic           m_tuser;           // [0] overflow

    sorted_res_t    sorted_expect [$];
    logic [VW-1:0]  held_vals [DEPTH];
    int             held_cnt     = 0;
    bit             held_ovf     = 1'b0;
    int             mismatch_cnt = 0;
    int             quiet_cycles = 0;
    bit             tx_calm      = 1'b0;
    bit             rx_calm      = 1'b0;

    stim_row_t dir_table [DIR_ROWS] = '{
        // single-element sets: the value comes straight back
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{32'h5555_5555, 1'b1, 1'b1, 32'h5555_5555, 1'b1, 1'b0},
        '{32'hAAAA_AAAA, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0},
        // extremes around the sign boundary
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'h0000_0001, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        // duplicates
        '{32'h0000_0005, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'hFFFF_FFFB, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'h0000_0005, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        // descending pair
        '{32'h0000_0007, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'hFFFF_FFF9, 1'b1, 1'b0, '0, 1'b0, 1'b0},
        // all equal
        '{32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, '0, 1'b0, 1'b0}
    };

    merge_sorter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Store one accepted value (flag overflow when full); on a closing request sort
    // the set and, with queue_res, queue one expected result per held element.
    task automatic absorb_value(input logic [VW-1:0] val, input bit closes,
                                input bit queue_res);
        logic [VW-1:0] key;
        int            j;
        sorted_res_t   res;
        if (held_cnt < DEPTH) begin
            held_vals[held_cnt] = val;
            held_cnt++;
        end else begin
            held_ovf = 1'b1;
        end
        if (closes) begin
            for (int i = 1; i < held_cnt; i++) begin
                key = held_vals[i];
                j   = i - 1;
                while (j >= 0 && $signed(held_vals[j]) > $signed(key)) begin
                    held_vals[j + 1] = held_vals[j];
                    j--;
                end
                held_vals[j + 1] = key;
            end
            if (queue_res) begin
                for (int k = 0; k < held_cnt; k++) begin
                    res.value = held_vals[k];
                    res.fin   = (k == held_cnt - 1);
                    res.ovf   = held_ovf;
                    sorted_expect.push_back(res);
                end
            end
            held_cnt = 0;
            held_ovf = 1'b0;
        end
    endtask

    // drain: hold off until every queued result has been taken
    task automatic send_value(input logic [VW-1:0] val, input bit closes,
                              input bit queue_res, input bit drain);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            while (drain && sorted_expect.size() != 0) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDW'(val);
        s_tlast  <= closes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_value(val, closes, queue_res);
    endtask

    function automatic logic [VW-1:0] draw_value(input logic [VW-1:0] prev);
        logic [VW-1:0] v;
        case ($urandom_range(0, 5))
            0, 1:    v = $urandom;
            2:       v = VW'($urandom_range(0, 40)) - VW'(20);
            3:       v = prev;
            4: begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(VW-1){1'b0}}};
                    1:       v = {1'b0, {(VW-1){1'b1}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom ^ 32'h8000_0000;
        endcase
        return v;
    endfunction

    task automatic send_set(input int size, input bit drain);
        logic [VW-1:0] val;
        val     = '0;
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < size; i++) begin
            val = draw_value(val);
            send_value(val, i == size - 1, 1'b1, drain && i == 0);
        end
    endtask

    // result side: random stalls, compare in order
    initial begin : result_check
        int          stall;
        sorted_res_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (sorted_expect.size() == 0) begin
                $display("%0t: unexpected result value=%0d last=%0b ovf=%0b", $time,
                         $signed(m_tdata[VW-1:0]), m_tlast, m_tuser);
                mismatch_cnt++;
            end else begin
                want = sorted_expect.pop_front();
                if (m_tdata[VW-1:0] !== want.value) begin
                    $display("%0t: sorted_value expected %0d got %0d", $time,
                             $signed(want.value), $signed(m_tdata[VW-1:0]));
                    mismatch_cnt++;
                end
                if (m_tlast !== want.fin) begin
                    $display("%0t: final_res expected %0b got %0b", $time,
                             want.fin, m_tlast);
                    mismatch_cnt++;
                end
                if (m_tuser !== want.ovf) begin
                    $display("%0t: overflow expected %0b got %0b", $time,
                             want.ovf, m_tuser);
                    mismatch_cnt++;
                end
            end
            if (m_tlast)
                rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL merge_sorter_top");
            $finish;
        end
    end

    initial begin : stimulus
        sorted_res_t row_res;
        int          set_idx;
        int          rand_done;
        int          size;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            tx_calm = ($urandom_range(0, 2) == 0);
            send_value(dir_table[r].value, dir_table[r].is_last,
                       !dir_table[r].typed, 1'b0);
            if (dir_table[r].typed) begin
                row_res.value = dir_table[r].exp_value;
                row_res.fin   = dir_table[r].exp_fin;
                row_res.ovf   = dir_table[r].exp_ovf;
                sorted_expect.push_back(row_res);
            end
        end

        // set 1 fills the buffer and overflows by exactly one (its last
        // request is dropped); the rest are mostly small
        set_idx   = 0;
        rand_done = 0;
        while (rand_done < RAND_ITEMS) begin
            if (set_idx == 1) begin
                size = DEPTH + 1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: size = $urandom_range(1, 6);
                    6, 7, 8:          size = $urandom_range(7, 16);
                    default:          size = $urandom_range(17, 40);
                endcase
                if (size > RAND_ITEMS - rand_done)
                    size = RAND_ITEMS - rand_done;
            end
            rand_done += size;
            send_set(size, set_idx == 0 || $urandom_range(0, 5) == 0);
            set_idx++;
        end

        s_tvalid <= 1'b0;
        while (sorted_expect.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("PASS merge_sorter_top");
        else
            $display("FAIL merge_sorter_top");
        $finish;
    end

endmodule

### files.f
sv/msort_pkg.sv
sv/msort_ram.sv
sv/msort_cmp.sv
sv/merge_sorter_top.sv
tb/merge_sorter_top_tb.sv
